// File: sv/trk_pkg.sv
// Shared types and constants of the tracker peak and report scheduler.
package trk_pkg;

  localparam int AXIS_W      = 12;
  localparam int MAG_W       = 11;
  localparam int SUM_W       = 24;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int ROOT_STEPS  = SUM_W / 2;
  localparam int MUL_A_W     = 12;
  localparam int MUL_B_W     = 24;
  localparam int MUL_R_W     = 32;

  // 15.987 * 2^20 rounded up; exact floor for every magnitude up to 128.
  localparam logic [MUL_B_W-1:0] SCALE_RECIP = 24'd16763585;
  localparam int                 SCALE_SHIFT = 20;

  localparam logic [2:0] HOLD_LIMIT = 3'd3;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int   CFG_AW     = 3;
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_LEAD   = 1'b1;

  localparam logic [15:0] PERIOD_RESET = 16'd60;
  localparam logic [15:0] LEAD_RESET   = 16'd10;

  typedef struct packed {
    logic              kind;
    logic              hall_active;
    logic signed [7:0] x_raw;
    logic signed [7:0] y_raw;
    logic signed [7:0] z_raw;
  } in_item_t;

  typedef struct packed {
    logic                     led_red;
    logic                     led_blue;
    logic                     tracking_on;
    logic                     gps_start;
    logic                     report_valid;
    logic signed [AXIS_W-1:0] peak_x;
    logic signed [AXIS_W-1:0] peak_y;
    logic signed [AXIS_W-1:0] peak_z;
  } out_item_t;

  typedef struct packed {
    logic [15:0] report_period;
    logic [15:0] gps_lead;
  } cfg_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic              work;
    logic              report;
    logic              gps;
    logic              mode;
    logic              led_red;
    logic              led_blue;
    logic signed [7:0] x_raw;
    logic signed [7:0] y_raw;
    logic signed [7:0] z_raw;
  } job_t;

endpackage

// File: sv/trk_front.sv
// Front end: accepts requests, runs the tick counter, hall hold and arming flags.
module trk_front import trk_pkg::*; #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     q_full,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     push,
  output job_t     job
);

  localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

  logic [COUNTER_WIDTH-1:0] tick_r, tick_nxt, tick_inc, target;
  logic [2:0]               hold_r, hold_nxt, hold_inc;
  logic                     mode_r, mode_nxt;
  logic                     gps_arm_r, gps_arm_nxt;
  logic                     rep_arm_r, rep_arm_nxt;
  logic                     red_r, red_nxt;
  logic                     blue_r, blue_nxt;

  assign push = in_valid & ~q_full;

  always_comb begin
    tick_inc    = tick_r + COUNTER_WIDTH'(1);
    target      = COUNTER_WIDTH'(cfg.report_period) - COUNTER_WIDTH'(cfg.gps_lead);
    hold_inc    = hold_r + 3'd1;
    tick_nxt    = tick_r;
    hold_nxt    = hold_r;
    mode_nxt    = mode_r;
    gps_arm_nxt = gps_arm_r;
    rep_arm_nxt = rep_arm_r;
    red_nxt     = red_r;
    blue_nxt    = blue_r;
    job.work    = 1'b0;
    job.report  = 1'b0;
    job.gps     = 1'b0;
    job.x_raw   = in_data.x_raw;
    job.y_raw   = in_data.y_raw;
    job.z_raw   = in_data.z_raw;

    if (in_data.kind == KIND_TICK) begin
      if (mode_r) begin
        if (tick_inc == target) begin
          gps_arm_nxt = 1'b1;
        end
        if (CMP_W'(tick_inc) >= CMP_W'(cfg.report_period)) begin
          rep_arm_nxt = 1'b1;
          tick_nxt    = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end else begin
        tick_nxt = '0;
      end
    end else begin
      if (in_data.hall_active) begin
        red_nxt  = ~mode_r;
        blue_nxt = mode_r;
        hold_nxt = hold_inc;
        // A long enough hold flips the mode and leaves both LEDs lit.
        if (hold_inc > HOLD_LIMIT) begin
          mode_nxt = ~mode_r;
          hold_nxt = '0;
          red_nxt  = 1'b1;
          blue_nxt = 1'b1;
        end
      end else begin
        red_nxt  = 1'b1;
        blue_nxt = 1'b1;
        hold_nxt = '0;
      end
      if (mode_nxt) begin
        job.work    = 1'b1;
        job.gps     = gps_arm_r;
        job.report  = rep_arm_r;
        gps_arm_nxt = 1'b0;
        rep_arm_nxt = 1'b0;
      end
    end

    job.mode     = mode_nxt;
    job.led_red  = red_nxt;
    job.led_blue = blue_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      hold_r    <= '0;
      mode_r    <= 1'b1;
      gps_arm_r <= 1'b0;
      rep_arm_r <= 1'b0;
      red_r     <= 1'b1;
      blue_r    <= 1'b1;
    end else if (push) begin
      tick_r    <= tick_nxt;
      hold_r    <= hold_nxt;
      mode_r    <= mode_nxt;
      gps_arm_r <= gps_arm_nxt;
      rep_arm_r <= rep_arm_nxt;
      red_r     <= red_nxt;
      blue_r    <= blue_nxt;
    end
  end

endmodule

// File: sv/trk_fifo.sv
// Short request queue between the front end and the back end.
module trk_fifo import trk_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (FIFO_AW+1)'(1);
        2'b01:   count_r <= count_r - (FIFO_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: sv/trk_back.sv
// Back end: scales the axes, finds the magnitude root, keeps the peak and drives results.
module trk_back import trk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCALE  = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam int         IT_W      = $clog2(ROOT_STEPS);
  localparam logic [1:0] LAST_AXIS = 2'd2;

  logic [2:0]               state_r;
  job_t                     job_r;
  logic [1:0]               idx_r;
  logic                     ph_r;
  logic [IT_W-1:0]          it_r;
  logic [MUL_R_W-1:0]       mul_r;
  logic signed [AXIS_W-1:0] axis_r [3];
  logic [MAG_W-1:0]         amag_r [3];
  logic [SUM_W-1:0]         rem_r, root_r, bit_r;
  logic signed [AXIS_W-1:0] peak_r [3];
  logic [ROOT_W-1:0]        peak_mag_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic signed [7:0]                raw_sel;
  logic [7:0]                       raw_abs;
  logic [MUL_A_W-1:0]               mul_a;
  logic [MUL_B_W-1:0]               mul_b;
  logic [MUL_A_W+MUL_B_W-1:0]       mul_p;
  logic [MAG_W-1:0]                 q_mag;
  logic signed [AXIS_W-1:0]         axis_new;
  logic [SUM_W:0]                   trial;
  logic                             take;
  logic                             cand_gt;
  logic                             out_free;
  logic                             finish;
  logic signed [AXIS_W-1:0]         pick [3];
  out_item_t                        out_nxt;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_DONE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (idx_r)
      2'd0:    raw_sel = job_r.x_raw;
      2'd1:    raw_sel = job_r.y_raw;
      default: raw_sel = job_r.z_raw;
    endcase
    raw_abs = raw_sel[7] ? 8'(-raw_sel) : raw_sel;

    // One shared multiplier: axis scaling first, squaring afterwards.
    if (state_r == ST_SCALE) begin
      mul_a = {4'b0, raw_abs};
      mul_b = SCALE_RECIP;
    end else begin
      mul_a = {1'b0, amag_r[idx_r]};
      mul_b = {13'b0, amag_r[idx_r]};
    end
    mul_p = mul_a * mul_b;

    q_mag    = mul_r[SCALE_SHIFT+MAG_W-1:SCALE_SHIFT];
    axis_new = raw_sel[7] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    trial   = {1'b0, root_r} + {1'b0, bit_r};
    take    = ({1'b0, rem_r} >= trial);
    cand_gt = root_r[ROOT_W-1:0] > peak_mag_r;

    for (int k = 0; k < 3; k++) begin
      pick[k] = cand_gt ? axis_r[k] : peak_r[k];
    end

    out_nxt.led_red      = job_r.led_red;
    out_nxt.led_blue     = job_r.led_blue;
    out_nxt.tracking_on  = job_r.mode;
    out_nxt.gps_start    = job_r.gps;
    out_nxt.report_valid = job_r.report;
    out_nxt.peak_x       = job_r.report ? pick[0] : '0;
    out_nxt.peak_y       = job_r.report ? pick[1] : '0;
    out_nxt.peak_z       = job_r.report ? pick[2] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      ph_r        <= 1'b0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
      peak_mag_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        peak_r[k] <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= q_data.work ? ST_SCALE : ST_DONE;
            idx_r   <= '0;
            ph_r    <= 1'b0;
          end
        end
        ST_SCALE: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (idx_r == LAST_AXIS) begin
              idx_r   <= '0;
              state_r <= ST_SQUARE;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end
        end
        ST_SQUARE: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (idx_r == LAST_AXIS) begin
              idx_r   <= '0;
              it_r    <= '0;
              state_r <= ST_ROOT;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end
        end
        ST_ROOT: begin
          it_r <= it_r + IT_W'(1);
          if (it_r == IT_W'(ROOT_STEPS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
            if (job_r.work) begin
              // A report hands out the peak and starts the next window from zero.
              if (job_r.report) begin
                peak_mag_r <= '0;
                for (int k = 0; k < 3; k++) begin
                  peak_r[k] <= '0;
                end
              end else begin
                if (cand_gt) begin
                  peak_mag_r <= root_r[ROOT_W-1:0];
                end
                for (int k = 0; k < 3; k++) begin
                  peak_r[k] <= pick[k];
                end
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= q_data;
      rem_r  <= '0;
      root_r <= '0;
      bit_r  <= SUM_W'(1) << (SUM_W - 2);
    end
    case (state_r)
      ST_SCALE: begin
        if (!ph_r) begin
          mul_r <= mul_p[MUL_R_W-1:0];
        end else begin
          axis_r[idx_r] <= axis_new;
          amag_r[idx_r] <= q_mag;
        end
      end
      ST_SQUARE: begin
        if (!ph_r) begin
          mul_r <= mul_p[MUL_R_W-1:0];
        end else begin
          rem_r <= rem_r + mul_r[SUM_W-1:0];
        end
      end
      ST_ROOT: begin
        if (take) begin
          rem_r  <= rem_r - trial[SUM_W-1:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: begin
      end
    endcase
    if (finish) begin
      out_data_r <= out_nxt;
    end
  end

  a_peak_zero_without_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.report_valid) |->
      (out_data_r.peak_x == '0 && out_data_r.peak_y == '0 && out_data_r.peak_z == '0))
    else $error("peak fields nonzero on a result without a report");

  a_report_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && job_r.work && job_r.report) |=>
      (peak_mag_r == '0 && peak_r[0] == '0 && peak_r[1] == '0 && peak_r[2] == '0))
    else $error("peak not cleared after a report");

  a_pulses_need_tracking: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.gps_start || out_data_r.report_valid)) |->
      out_data_r.tracking_on)
    else $error("gps or report pulse while tracking is off");

endmodule

// File: sv/tracker_peak_and_report_scheduler.sv
// Top level of the tracker peak and report scheduler.
//
// Input requests (in_valid, in_stall, in_data) are either timer ticks or
// sensor samples; each produces exactly one result on out_valid, out_stall,
// out_data, in request order. A request is taken on a rising edge with valid
// high and stall low on its channel.
// The front end takes one request per cycle, while the queue is not full, into
// a four-entry queue. The back end drains it one request at a time: a tick or
// a sample taken while tracking is off goes straight from the queue to the
// output register; a tracked sample first passes the shared multiplier (three
// scaling and three squaring steps) and the 12-step integer square root.
// When out_stall is high the output register holds its result, the back end
// waits with the next one, and in_stall rises once the queue is full.
// Reset (rst_n low, synchronous) turns tracking on, lights both LEDs, clears
// the counter, flags and peak, and loads report_period 60 and gps_lead 10.
// The APB-style port holds report_period at address 0 and gps_lead at 4; the
// user must write it only while no request is in flight, which no logic checks.
module tracker_peak_and_report_scheduler import trk_pkg::*; #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] period_r;
  logic [15:0] lead_r;
  cfg_t        cfg;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  job_t        q_data;

  assign pready            = 1'b1;
  assign cfg.report_period = period_r;
  assign cfg.gps_lead      = lead_r;
  assign prdata            = {16'b0, (paddr[2] == REG_LEAD) ? lead_r : period_r};
  assign in_stall          = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      lead_r   <= LEAD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_PERIOD) begin
        period_r <= pwdata[15:0];
      end else begin
        lead_r <= pwdata[15:0];
      end
    end
  end

  trk_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_data  (in_data),
    .cfg      (cfg),
    .push     (push),
    .job      (push_job)
  );

  trk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  trk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
